// ===== rtl/isr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isr_pkg: shared types and constants of the image resize sampler
// Sizes, fixed-point format, transaction structs and the queue entry format.
// ----------------------------------------------------------------------------
package isr_pkg;

    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int FRAC_BITS      = 16;

    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int XW          = $clog2(MAX_SRC_WIDTH);
    localparam int YW          = $clog2(MAX_SRC_HEIGHT);

    localparam int SRC_W      = 9;
    localparam int DST_W      = 13;
    localparam int COORD_W    = 12;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int STEP_W     = SRC_W + FRAC_BITS;
    localparam int POS_W      = COORD_W + STEP_W;
    localparam int WT_W       = FRAC_BITS + 1;
    localparam int H_W        = CH_W + FRAC_BITS;
    localparam int ACC_W      = H_W + WT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_INTERP     = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    typedef enum logic {
        MODE_NEAREST  = 1'b0,
        MODE_BILINEAR = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        K_WRITE,
        K_NEAREST,
        K_BILIN,
        K_RANGE
    } t_kind;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] row_index;
        logic [COORD_W-1:0] col_index;
        logic [CH_W-1:0]    in_red;
        logic [CH_W-1:0]    in_green;
        logic [CH_W-1:0]    in_blue;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic            range_error;
    } t_out_item;

    // effective sizes and steps seen by the front end
    typedef struct packed {
        logic [SRC_W-1:0]  sw;
        logic [SRC_W-1:0]  sh;
        logic [DST_W-1:0]  dw;
        logic [DST_W-1:0]  dh;
        logic              mode;
        logic [STEP_W-1:0] x_step;
        logic [STEP_W-1:0] y_step;
    } t_cfg;

    // addr order: 0 = (y0,x0), 1 = (y1,x0), 2 = (y0,x1), 3 = (y1,x1)
    typedef struct packed {
        t_kind                  kind;
        logic [3:0][ADDR_W-1:0] addr;
        logic [FRAC_BITS-1:0]   u;
        logic [FRAC_BITS-1:0]   v;
        logic [PIX_W-1:0]       pix;
    } t_qentry;

endpackage
`default_nettype wire

// ===== rtl/image_resize_sampler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// image_resize_sampler: nearest / bilinear image scaler
// Frame store of source RGB pixels and a resampler for destination pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: start/busy. A transaction is taken on a clock edge with
//   start high and busy low. cmd 0 writes a source pixel (no result; writes
//   outside the source size are dropped), cmd 1 samples a destination pixel.
//   Result channel: o_done is high for one cycle with o_result; there is no
//   back pressure, so every result must be taken in that cycle.
//   Config port: i_cfg_we/i_cfg_idx/i_cfg_data, written only while idle.
//   Each write to index 0..4 retriggers the step divider (25 quotient bits,
//   one per cycle); busy stays high after the write until the divider ends.
// Flow:
//   An accepted transaction passes the front-end registers r_a and r_b into
//   the queue. The back end then does a bilinear sample as four single-port
//   store reads plus two blend stages, a nearest sample as one read, and a
//   range error or write directly. The front end takes no new transaction
//   until the last one is in the queue, nor while the queue is full.
// Reset: control state clears, size registers go to 256, mode to bilinear
//   and both steps to zero; frame store contents are undefined until written.
// ----------------------------------------------------------------------------
module image_resize_sampler (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire isr_pkg::t_in_item              i_item,
    output logic                                o_done,
    output isr_pkg::t_out_item                  o_result,
    input  wire logic                           i_cfg_we,
    input  wire logic [isr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [isr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import isr_pkg::*;

    logic [SRC_W-1:0] r_src_w, r_src_h;
    logic [DST_W-1:0] r_dst_w, r_dst_h;
    logic             r_mode;
    logic             r_cfg_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w   <= SRC_W'(256);
            r_src_h   <= SRC_W'(256);
            r_dst_w   <= DST_W'(256);
            r_dst_h   <= DST_W'(256);
            r_mode    <= MODE_BILINEAR;
            r_cfg_upd <= 1'b0;
        end else begin
            r_cfg_upd <= i_cfg_we && (i_cfg_idx <= CFG_INTERP);
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SRC_WIDTH:  r_src_w <= i_cfg_data[SRC_W-1:0];
                    CFG_SRC_HEIGHT: r_src_h <= i_cfg_data[SRC_W-1:0];
                    CFG_DST_WIDTH:  r_dst_w <= i_cfg_data[DST_W-1:0];
                    CFG_DST_HEIGHT: r_dst_h <= i_cfg_data[DST_W-1:0];
                    CFG_INTERP:     r_mode  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    t_cfg              cfg;
    logic [SRC_W-1:0]  num_x, num_y;
    logic              div_busy;
    logic [STEP_W-1:0] x_step, y_step;

    always_comb begin
        cfg.sw = (r_src_w == '0) ? SRC_W'(1) :
                 (r_src_w > SRC_W'(MAX_SRC_WIDTH)) ? SRC_W'(MAX_SRC_WIDTH) : r_src_w;
        cfg.sh = (r_src_h == '0) ? SRC_W'(1) :
                 (r_src_h > SRC_W'(MAX_SRC_HEIGHT)) ? SRC_W'(MAX_SRC_HEIGHT) : r_src_h;
        cfg.dw     = (r_dst_w == '0) ? DST_W'(1) : r_dst_w;
        cfg.dh     = (r_dst_h == '0) ? DST_W'(1) : r_dst_h;
        cfg.mode   = r_mode;
        cfg.x_step = x_step;
        cfg.y_step = y_step;
        num_x = (r_mode == MODE_BILINEAR) ? cfg.sw - 1'b1 : cfg.sw;
        num_y = (r_mode == MODE_BILINEAR) ? cfg.sh - 1'b1 : cfg.sh;
    end

    isr_stepdiv u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_cfg_upd),
        .i_num_x  (num_x),
        .i_den_x  (cfg.dw),
        .i_num_y  (num_y),
        .i_den_y  (cfg.dh),
        .o_busy   (div_busy),
        .o_x_step (x_step),
        .o_y_step (y_step)
    );

    logic    accept, front_busy, push, pop, q_empty, q_full;
    t_qentry entry, head;

    assign busy   = r_cfg_upd || div_busy || front_busy || q_full;
    assign accept = start && !busy;

    isr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .i_cfg    (cfg),
        .o_busy   (front_busy),
        .o_push   (push),
        .o_entry  (entry)
    );

    isr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    isr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!q_empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

// ===== rtl/isr_stepdiv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isr_stepdiv: source step divider
// Restoring divider, one quotient bit per cycle, x and y lanes side by side.
// ----------------------------------------------------------------------------
module isr_stepdiv (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [isr_pkg::SRC_W-1:0] i_num_x,
    input  wire logic [isr_pkg::DST_W-1:0] i_den_x,
    input  wire logic [isr_pkg::SRC_W-1:0] i_num_y,
    input  wire logic [isr_pkg::DST_W-1:0] i_den_y,
    output logic                           o_busy,
    output logic [isr_pkg::STEP_W-1:0]     o_x_step,
    output logic [isr_pkg::STEP_W-1:0]     o_y_step
);
    import isr_pkg::*;

    localparam int CNT_W = $clog2(STEP_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [STEP_W-1:0] r_dvd_x, r_dvd_y, r_q_x, r_q_y;
    logic [DST_W:0]    r_rem_x, r_rem_y;
    logic [DST_W-1:0]  r_den_x, r_den_y;
    logic [STEP_W-1:0] r_x_step, r_y_step;

    logic [DST_W:0]    sh_x, sh_y, n_rem_x, n_rem_y;
    logic [STEP_W-1:0] n_q_x, n_q_y;

    always_comb begin
        sh_x = {r_rem_x[DST_W-1:0], r_dvd_x[STEP_W-1]};
        sh_y = {r_rem_y[DST_W-1:0], r_dvd_y[STEP_W-1]};
        if (sh_x >= {1'b0, r_den_x}) begin
            n_rem_x = sh_x - {1'b0, r_den_x};
            n_q_x   = {r_q_x[STEP_W-2:0], 1'b1};
        end else begin
            n_rem_x = sh_x;
            n_q_x   = {r_q_x[STEP_W-2:0], 1'b0};
        end
        if (sh_y >= {1'b0, r_den_y}) begin
            n_rem_y = sh_y - {1'b0, r_den_y};
            n_q_y   = {r_q_y[STEP_W-2:0], 1'b1};
        end else begin
            n_rem_y = sh_y;
            n_q_y   = {r_q_y[STEP_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_cnt    <= '0;
            r_x_step <= '0;
            r_y_step <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_cnt   <= CNT_W'(STEP_W);
            r_dvd_x <= {i_num_x, {FRAC_BITS{1'b0}}};
            r_dvd_y <= {i_num_y, {FRAC_BITS{1'b0}}};
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_q_x   <= '0;
            r_q_y   <= '0;
            r_den_x <= i_den_x;
            r_den_y <= i_den_y;
        end else if (r_busy) begin
            r_dvd_x <= {r_dvd_x[STEP_W-2:0], 1'b0};
            r_dvd_y <= {r_dvd_y[STEP_W-2:0], 1'b0};
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_q_x   <= n_q_x;
            r_q_y   <= n_q_y;
            r_cnt   <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy   <= 1'b0;
                r_x_step <= n_q_x;
                r_y_step <= n_q_y;
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_x_step = r_x_step;
    assign o_y_step = r_y_step;

endmodule
`default_nettype wire

// ===== rtl/isr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isr_front: transaction front end
// Registers a transaction, scales its coordinates, classifies it and builds
// the frame store addresses and blend weights for the back end.
// ----------------------------------------------------------------------------
module isr_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire isr_pkg::t_in_item i_item,
    input  wire isr_pkg::t_cfg     i_cfg,
    output logic                   o_busy,
    output logic                   o_push,
    output isr_pkg::t_qentry       o_entry
);
    import isr_pkg::*;

    logic             r_a_v;
    t_in_item         r_a;
    logic             r_b_v;
    t_kind            r_b_kind;
    logic [POS_W-1:0] r_b_px, r_b_py;
    logic [ADDR_W-1:0] r_b_waddr;
    logic [PIX_W-1:0] r_b_pix;

    function automatic logic [ADDR_W-1:0] pix_addr(input logic [SRC_W-1:0] y,
                                                   input logic [SRC_W-1:0] x);
        pix_addr = ADDR_W'(ADDR_W'(y) * ADDR_W'(MAX_SRC_WIDTH) + ADDR_W'(x));
    endfunction

    // classification of the registered transaction
    logic  a_keep;
    t_kind a_kind;
    always_comb begin
        a_keep = 1'b1;
        a_kind = K_WRITE;
        if (r_a.cmd == CMD_WRITE) begin
            a_keep = (r_a.row_index < COORD_W'(i_cfg.sh)) &&
                     (r_a.col_index < COORD_W'(i_cfg.sw));
        end else if (({1'b0, r_a.row_index} >= i_cfg.dh) ||
                     ({1'b0, r_a.col_index} >= i_cfg.dw)) begin
            a_kind = K_RANGE;
        end else if (i_cfg.mode == MODE_BILINEAR) begin
            a_kind = K_BILIN;
        end else begin
            a_kind = K_NEAREST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            r_a_v <= i_accept;
            r_b_v <= r_a_v && a_keep;
        end
        if (i_accept) begin
            r_a <= i_item;
        end
        r_b_kind  <= a_kind;
        r_b_px    <= POS_W'(r_a.col_index) * POS_W'(i_cfg.x_step);
        r_b_py    <= POS_W'(r_a.row_index) * POS_W'(i_cfg.y_step);
        r_b_waddr <= pix_addr(SRC_W'(r_a.row_index[YW-1:0]), SRC_W'(r_a.col_index[XW-1:0]));
        r_b_pix   <= {r_a.in_blue, r_a.in_green, r_a.in_red};
    end

    // coordinate math on the scaled positions
    logic [SRC_W-1:0]       sw_m1, sh_m1, xi, yi, x0, y0, x1, y1;
    logic [POS_W:0]         xr, yr;
    logic [POS_W-FRAC_BITS-1:0] xf, yf;
    always_comb begin
        sw_m1 = i_cfg.sw - 1'b1;
        sh_m1 = i_cfg.sh - 1'b1;
        // nearest: round half up, clamp to the last pixel
        xr = ({1'b0, r_b_px} + (POS_W+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        yr = ({1'b0, r_b_py} + (POS_W+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        xi = (xr > (POS_W+1)'(sw_m1)) ? sw_m1 : SRC_W'(xr);
        yi = (yr > (POS_W+1)'(sh_m1)) ? sh_m1 : SRC_W'(yr);
        // bilinear: integer part and its right/lower neighbor, both clamped
        xf = r_b_px[POS_W-1:FRAC_BITS];
        yf = r_b_py[POS_W-1:FRAC_BITS];
        x0 = (xf > (POS_W-FRAC_BITS)'(sw_m1)) ? sw_m1 : SRC_W'(xf);
        y0 = (yf > (POS_W-FRAC_BITS)'(sh_m1)) ? sh_m1 : SRC_W'(yf);
        x1 = (x0 >= sw_m1) ? sw_m1 : x0 + 1'b1;
        y1 = (y0 >= sh_m1) ? sh_m1 : y0 + 1'b1;

        o_entry      = '0;
        o_entry.kind = r_b_kind;
        o_entry.pix  = r_b_pix;
        case (r_b_kind)
            K_WRITE: begin
                o_entry.addr[0] = r_b_waddr;
            end
            K_NEAREST: begin
                o_entry.addr[0] = pix_addr(yi, xi);
            end
            K_BILIN: begin
                o_entry.addr[0] = pix_addr(y0, x0);
                o_entry.addr[1] = pix_addr(y1, x0);
                o_entry.addr[2] = pix_addr(y0, x1);
                o_entry.addr[3] = pix_addr(y1, x1);
                o_entry.u       = r_b_px[FRAC_BITS-1:0];
                o_entry.v       = r_b_py[FRAC_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    assign o_push = r_b_v;
    assign o_busy = r_a_v || r_b_v;

endmodule
`default_nettype wire

// ===== rtl/isr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isr_queue: classified transaction queue
// Small show-ahead FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module isr_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire isr_pkg::t_qentry i_entry,
    input  wire logic             i_pop,
    output isr_pkg::t_qentry      o_head,
    output logic                  o_empty,
    output logic                  o_full
);
    import isr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_qentry          r_buf [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
        if (i_push) begin
            r_buf[r_wr] <= i_entry;
        end
    end

    assign o_head  = r_buf[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== rtl/isr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isr_back: frame store and sampling engine
// Owns the single-port frame store, reads the neighbors one per cycle and
// blends them horizontally then vertically for a bilinear sample.
// ----------------------------------------------------------------------------
module isr_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire isr_pkg::t_qentry i_head,
    output logic                  o_pop,
    output logic                  o_done,
    output isr_pkg::t_out_item    o_result
);
    import isr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_HORZ,
        S_VERT
    } t_state;

    t_state            r_state;
    t_qentry           r_e;
    logic [1:0]        r_cnt;
    logic              r_rd_v;
    logic [1:0]        r_rd_idx;
    logic [3:0][PIX_W-1:0] r_px;
    logic [2:0][H_W-1:0]   r_h0, r_h1;
    logic              r_done;
    t_out_item         r_res;

    logic [PIX_W-1:0]  r_mem [STORE_DEPTH];
    logic [PIX_W-1:0]  r_mem_q;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;

    assign o_pop    = (r_state == S_IDLE) && i_valid;
    assign mem_we   = o_pop && (i_head.kind == K_WRITE);
    assign mem_addr = (r_state == S_READ) ? r_e.addr[r_cnt] : i_head.addr[0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= i_head.pix;
        end
        r_mem_q <= r_mem[mem_addr];
    end

    // horizontal blend: (1-u)*left + u*right per channel
    logic [WT_W-1:0]     wu0, wv0;
    logic [2:0][H_W-1:0] h0, h1;
    logic [2:0][CH_W:0]  vr;
    logic [ACC_W-1:0]    acc;
    logic                done_set;
    always_comb begin
        wu0 = WT_W'(1 << FRAC_BITS) - WT_W'(r_e.u);
        wv0 = WT_W'(1 << FRAC_BITS) - WT_W'(r_e.v);
        for (int k = 0; k < 3; k++) begin
            h0[k] = H_W'((H_W+1)'(wu0) * (H_W+1)'(r_px[0][8*k +: CH_W]) +
                         (H_W+1)'(r_e.u) * (H_W+1)'(r_px[2][8*k +: CH_W]));
            h1[k] = H_W'((H_W+1)'(wu0) * (H_W+1)'(r_px[1][8*k +: CH_W]) +
                         (H_W+1)'(r_e.u) * (H_W+1)'(r_px[3][8*k +: CH_W]));
        end
        acc = '0;
        for (int k = 0; k < 3; k++) begin
            acc = ACC_W'(wv0) * ACC_W'(r_h0[k]) + ACC_W'(r_e.v) * ACC_W'(r_h1[k]) +
                  ACC_W'(64'd1 << (2 * FRAC_BITS - 1));
            vr[k] = acc[ACC_W-1 -: CH_W+1];
        end
        done_set = ((r_state == S_IDLE) && i_valid && (i_head.kind == K_RANGE)) ||
                   ((r_state == S_HORZ) && (r_e.kind == K_NEAREST)) ||
                   (r_state == S_VERT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_rd_v  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= done_set;
            r_rd_v <= (r_state == S_READ);
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_e <= i_head;
                        unique case (i_head.kind)
                            K_RANGE: begin
                                r_res  <= '{out_red: '0, out_green: '0, out_blue: '0,
                                            range_error: 1'b1};
                            end
                            K_NEAREST, K_BILIN: begin
                                r_cnt   <= '0;
                                r_state <= S_READ;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_rd_idx <= r_cnt;
                    if (r_e.kind == K_NEAREST || r_cnt == 2'd3) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_WAIT: begin
                    r_state <= S_HORZ;
                end
                S_HORZ: begin
                    if (r_e.kind == K_NEAREST) begin
                        r_res   <= '{out_red: r_px[0][7:0], out_green: r_px[0][15:8],
                                     out_blue: r_px[0][23:16], range_error: 1'b0};
                        r_state <= S_IDLE;
                    end else begin
                        r_h0    <= h0;
                        r_h1    <= h1;
                        r_state <= S_VERT;
                    end
                end
                S_VERT: begin
                    r_res.range_error <= 1'b0;
                    r_res.out_red   <= (vr[0] > (CH_W+1)'(255)) ? 8'hFF : vr[0][CH_W-1:0];
                    r_res.out_green <= (vr[1] > (CH_W+1)'(255)) ? 8'hFF : vr[1][CH_W-1:0];
                    r_res.out_blue  <= (vr[2] > (CH_W+1)'(255)) ? 8'hFF : vr[2][CH_W-1:0];
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (r_rd_v) begin
                r_px[r_rd_idx] <= r_mem_q;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire
